// File: sv/pbcp_pkg.sv
// ----------------------------------------------------------------------------
// Pileup base column parser package
// Shared constants, types and character helpers of the parser.
// ----------------------------------------------------------------------------
package pbcp_pkg;

  localparam int unsigned DefaultMaxDepth = 1024;

  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;

  localparam logic [15:0] IndelMax = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_BASES = 3'd0,
    PH_SKIP1 = 3'd1,
    PH_LEN   = 3'd2,
    PH_SKIPN = 3'd3,
    PH_QUAL  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    KIND_PAIR     = 3'd0,
    KIND_SUMMARY  = 3'd1,
    KIND_UNKNOWN  = 3'd2,
    KIND_NO_BASE  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_e;

  // One parsed character as handed from the parser to the result stage.
  typedef struct packed {
    logic        err_v;
    kind_e       err_kind;
    logic [7:0]  err_char;
    logic        pair_v;
    logic [7:0]  qual;
    logic        line_end;
    logic [10:0] span;
  } item_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    to_upper = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
  endfunction

endpackage

// File: sv/pbcp_if.sv
// ----------------------------------------------------------------------------
// Pileup base column parser channels
// Valid/ready interfaces for the character input and the result output.
// ----------------------------------------------------------------------------
interface pbcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic [7:0] ref_base;
  logic       line_end;

  modport source (output valid, output ch, output ref_base, output line_end, input ready);
  modport sink (input valid, input ch, input ref_base, input line_end, output ready);
endinterface

interface pbcp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  base;
  logic [7:0]  base_upper;
  logic [7:0]  qual_code;
  logic [9:0]  match_index;
  logic [10:0] span_count;
  logic [10:0] match_count;
  logic        last;

  modport source (
    output valid, output kind, output base, output base_upper, output qual_code,
    output match_index, output span_count, output match_count, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input base, input base_upper, input qual_code,
    input match_index, input span_count, input match_count, input last,
    output ready
  );
endinterface

// File: sv/pbcp_slot_mem.sv
// ----------------------------------------------------------------------------
// Pileup base column parser slot memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbcp_slot_mem #(
  parameter int unsigned Depth = pbcp_pkg::DefaultMaxDepth,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pbcp_parse.sv
// ----------------------------------------------------------------------------
// Pileup base column parser front end
// Per-character line state, slot writes and quality-phase slot reads.
// ----------------------------------------------------------------------------
module pbcp_parse #(
  parameter int unsigned MaxDepth = pbcp_pkg::DefaultMaxDepth,
  localparam int unsigned AddrW = $clog2(MaxDepth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  logic [7:0]         ch_i,
  input  logic [7:0]         ref_base_i,
  input  logic               line_end_i,
  output pbcp_pkg::item_t    item_o,
  output logic               we_o,
  output logic [AddrW-1:0]   waddr_o,
  output logic [7:0]         wdata_o,
  output logic               re_o,
  output logic [AddrW-1:0]   raddr_o
);

  localparam int unsigned CntW = $clog2(MaxDepth + 1);

  pbcp_pkg::phase_e phase_q, phase_d;
  logic [CntW-1:0]  slot_q, slot_d;
  logic [CntW-1:0]  qslot_q, qslot_d;
  logic [15:0]      indel_q, indel_d;
  logic             err_q, err_d;

  logic             col_char;
  logic             st_v;
  logic [7:0]       st_val;
  logic [19:0]      len_prod;
  logic [15:0]      indel_dec;
  logic [CntW+10:0] span_wide;

  always_comb begin
    phase_d   = phase_q;
    slot_d    = slot_q;
    qslot_d   = qslot_q;
    indel_d   = indel_q;
    err_d     = err_q;
    col_char  = 1'b0;
    st_v      = 1'b0;
    st_val    = ch_i;
    we_o      = 1'b0;
    re_o      = 1'b0;
    item_o    = '0;
    item_o.err_kind = pbcp_pkg::KIND_UNKNOWN;
    item_o.qual     = ch_i;
    len_prod  = ({4'b0, indel_q} << 3) + ({4'b0, indel_q} << 1) + {16'b0, ch_i[3:0]};
    indel_dec = indel_q - 16'd1;

    if (!err_q) begin
      unique case (phase_q)
        pbcp_pkg::PH_BASES: begin
          col_char = 1'b1;
        end
        pbcp_pkg::PH_SKIP1: begin
          phase_d = pbcp_pkg::PH_BASES;
        end
        pbcp_pkg::PH_LEN: begin
          if (ch_i >= pbcp_pkg::ChZero && ch_i <= pbcp_pkg::ChNine) begin
            indel_d = (len_prod > {4'b0, pbcp_pkg::IndelMax}) ? pbcp_pkg::IndelMax
                                                              : len_prod[15:0];
          end else if (indel_q == '0) begin
            phase_d  = pbcp_pkg::PH_BASES;
            col_char = 1'b1;
          end else begin
            indel_d = indel_dec;
            phase_d = (indel_dec == '0) ? pbcp_pkg::PH_BASES : pbcp_pkg::PH_SKIPN;
          end
        end
        pbcp_pkg::PH_SKIPN: begin
          if (indel_q != '0) begin
            indel_d = indel_dec;
          end
          if (indel_q == '0 || indel_dec == '0) begin
            phase_d = pbcp_pkg::PH_BASES;
          end
        end
        pbcp_pkg::PH_QUAL: begin
          if (qslot_q >= slot_q) begin
            item_o.err_v    = 1'b1;
            item_o.err_kind = pbcp_pkg::KIND_NO_BASE;
            item_o.err_char = ch_i;
            err_d           = 1'b1;
          end else begin
            re_o          = fire_i;
            item_o.pair_v = 1'b1;
            qslot_d       = qslot_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (col_char) begin
      case (ch_i) inside
        "A", "C", "G", "T", "N", "a", "c", "g", "t", "n": begin
          st_v   = 1'b1;
          st_val = ch_i;
        end
        pbcp_pkg::ChDot: begin
          st_v   = 1'b1;
          st_val = pbcp_pkg::to_upper(ref_base_i);
        end
        pbcp_pkg::ChComma: begin
          st_v   = 1'b1;
          st_val = pbcp_pkg::to_lower(ref_base_i);
        end
        pbcp_pkg::ChStar: begin
          st_v   = 1'b1;
          st_val = pbcp_pkg::ChStar;
        end
        pbcp_pkg::ChCaret: begin
          phase_d = pbcp_pkg::PH_SKIP1;
        end
        pbcp_pkg::ChDollar: begin
        end
        pbcp_pkg::ChPlus, pbcp_pkg::ChMinus: begin
          indel_d = '0;
          phase_d = pbcp_pkg::PH_LEN;
        end
        pbcp_pkg::ChTab, pbcp_pkg::ChSpace: begin
          phase_d = pbcp_pkg::PH_QUAL;
          qslot_d = '0;
        end
        default: begin
          item_o.err_v    = 1'b1;
          item_o.err_kind = pbcp_pkg::KIND_UNKNOWN;
          item_o.err_char = ch_i;
          err_d           = 1'b1;
        end
      endcase
    end

    if (st_v) begin
      if (slot_q == CntW'(MaxDepth)) begin
        item_o.err_v    = 1'b1;
        item_o.err_kind = pbcp_pkg::KIND_OVERFLOW;
        item_o.err_char = st_val;
        err_d           = 1'b1;
      end else begin
        we_o   = fire_i;
        slot_d = slot_q + 1'b1;
      end
    end

    span_wide       = {11'b0, slot_d};
    item_o.line_end = line_end_i;
    item_o.span     = span_wide[10:0];

    if (line_end_i) begin
      phase_d = pbcp_pkg::PH_BASES;
      slot_d  = '0;
      qslot_d = '0;
      indel_d = '0;
      err_d   = 1'b0;
    end
  end

  assign waddr_o = slot_q[AddrW-1:0];
  assign wdata_o = st_val;
  assign raddr_o = qslot_q[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pbcp_pkg::PH_BASES;
      slot_q  <= '0;
      qslot_q <= '0;
      indel_q <= '0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      qslot_q <= qslot_d;
      indel_q <= indel_d;
      err_q   <= err_d;
    end
  end

endmodule

// File: sv/pbcp_emit.sv
// ----------------------------------------------------------------------------
// Pileup base column parser result stage
// Joins slot read data with the parsed character, keeps the match count and
// sends at most two results through the output register.
// ----------------------------------------------------------------------------
module pbcp_emit #(
  parameter int unsigned MaxDepth = pbcp_pkg::DefaultMaxDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  pbcp_pkg::item_t item_i,
  input  logic [7:0]      rdata_i,
  output logic            accept_o,
  pbcp_out_if.source      out_o
);

  localparam int unsigned CntW = $clog2(MaxDepth + 1);

  logic             s1_v_q;
  pbcp_pkg::item_t  item_q;
  logic             sel_q;
  logic [CntW-1:0]  mcnt_q;

  logic             out_v_q;
  logic [2:0]       kind_q;
  logic [7:0]       base_q;
  logic [7:0]       upper_q;
  logic [7:0]       qual_q;
  logic [9:0]       midx_q;
  logic [10:0]      span_q;
  logic [10:0]      mc_q;
  logic             last_q;

  logic             pair_ok;
  logic             a_pend;
  logic             pend;
  logic             out_free;
  logic             mv;
  logic             cur_last;
  logic             done;
  logic [CntW-1:0]  mcnt_inc;
  logic [CntW+10:0] midx_wide;
  logic [CntW+10:0] mc_wide;

  always_comb begin
    pair_ok   = item_q.pair_v && (rdata_i != pbcp_pkg::ChStar);
    a_pend    = (item_q.err_v || pair_ok) && !sel_q;
    pend      = a_pend || item_q.line_end;
    out_free  = !out_v_q || out_o.ready;
    mv        = s1_v_q && pend && out_free;
    cur_last  = !(a_pend && item_q.line_end);
    done      = s1_v_q && (!pend || (mv && cur_last));
    mcnt_inc  = mcnt_q + {{(CntW-1){1'b0}}, pair_ok};
    midx_wide = {11'b0, mcnt_q};
    mc_wide   = {11'b0, mcnt_inc};
  end

  assign accept_o = !s1_v_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      sel_q  <= 1'b0;
      mcnt_q <= '0;
    end else begin
      if (done) begin
        mcnt_q <= item_q.line_end ? '0 : mcnt_inc;
      end
      if (fire_i) begin
        s1_v_q <= 1'b1;
        sel_q  <= 1'b0;
      end else if (done) begin
        s1_v_q <= 1'b0;
      end else if (mv) begin
        sel_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      item_q <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (mv) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv) begin
      last_q  <= cur_last;
      kind_q  <= pbcp_pkg::KIND_SUMMARY;
      base_q  <= '0;
      upper_q <= '0;
      qual_q  <= '0;
      midx_q  <= '0;
      span_q  <= '0;
      mc_q    <= '0;
      if (a_pend && item_q.err_v) begin
        kind_q <= item_q.err_kind;
        base_q <= item_q.err_char;
      end else if (a_pend) begin
        kind_q  <= pbcp_pkg::KIND_PAIR;
        base_q  <= rdata_i;
        upper_q <= pbcp_pkg::to_upper(rdata_i);
        qual_q  <= item_q.qual;
        midx_q  <= midx_wide[9:0];
      end else begin
        span_q <= item_q.span;
        mc_q   <= mc_wide[10:0];
      end
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.kind        = kind_q;
  assign out_o.base        = base_q;
  assign out_o.base_upper  = upper_q;
  assign out_o.qual_code   = qual_q;
  assign out_o.match_index = midx_q;
  assign out_o.span_count  = span_q;
  assign out_o.match_count = mc_q;
  assign out_o.last        = last_q;

endmodule

// File: sv/pileup_base_column_parser_top.sv
// ----------------------------------------------------------------------------
// Pileup base column parser
// Parses the read-base column and quality string of a pileup line, one
// character per beat, and returns paired bases, errors and line summaries.
// ----------------------------------------------------------------------------
//   Channel  Direction  Beat carries
//   in_i     sink       ch, ref_base, line_end
//   out_o    source     kind, base, base_upper, qual_code, match_index,
//                       span_count, match_count, last
//
// At most one character is taken per cycle; its result passes the result
// stage, then the output register. A character that gives both a base or
// error result and the line summary holds the input until both are sent,
// as the output register sends at most one result per cycle. The slot memory takes
// at most one write in the base column or one read in the quality string per
// character. Reset clears the line state at once; the slot memory needs no
// clearing. A stalled output holds the result stage, which then holds the input.
module pileup_base_column_parser_top #(
  parameter int unsigned MaxDepth = pbcp_pkg::DefaultMaxDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbcp_in_if.sink    in_i,
  pbcp_out_if.source out_o
);

  localparam int unsigned AddrW = $clog2(MaxDepth);

  pbcp_pkg::item_t  item;
  logic             fire;
  logic             accept;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [7:0]       wdata;
  logic             re;
  logic [AddrW-1:0] raddr;
  logic [7:0]       rdata;

  assign in_i.ready = accept;
  assign fire       = in_i.valid && accept;

  pbcp_parse #(
    .MaxDepth(MaxDepth)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .ch_i       (in_i.ch),
    .ref_base_i (in_i.ref_base),
    .line_end_i (in_i.line_end),
    .item_o     (item),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr)
  );

  pbcp_slot_mem #(
    .Depth(MaxDepth)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pbcp_emit #(
    .MaxDepth(MaxDepth)
  ) u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .rdata_i  (rdata),
    .accept_o (accept),
    .out_o    (out_o)
  );

endmodule
